// File: hdl/landmark_association_mahalanobis_defines.svh
// Assertion helpers shared by the checker.
`ifndef LANDMARK_ASSOCIATION_MAHALANOBIS_DEFINES_SVH
`define LANDMARK_ASSOCIATION_MAHALANOBIS_DEFINES_SVH

// Check on every clock edge outside reset.
`define LAM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check on every clock edge, reset included.
`define LAM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: hdl/lam_pkg.sv
`timescale 1ns / 1ps
package lam_pkg;

    typedef struct packed {
        logic [15:0] angle_std;
        logic [15:0] distance_std;
        logic [15:0] compass_std;
        logic [14:0] range_gate;
    } cfg_t;

    localparam logic [1:0] CFG_ANGLE_STD    = 2'd0;
    localparam logic [1:0] CFG_DISTANCE_STD = 2'd1;
    localparam logic [1:0] CFG_COMPASS_STD  = 2'd2;
    localparam logic [1:0] CFG_RANGE_GATE   = 2'd3;

    localparam logic [15:0] ANGLE_STD_RST    = 16'd3277;
    localparam logic [15:0] DISTANCE_STD_RST = 16'd8192;
    localparam logic [15:0] COMPASS_STD_RST  = 16'd12868;
    localparam logic [14:0] RANGE_GATE_RST   = 15'd7168;

    // Classified candidate handed from front to back.
    typedef struct packed {
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic [15:0]        heading;
        logic [14:0]        range;
        logic [15:0]        bearing;
        logic [15:0]        ori_innov;
        logic               gate_open;
        logic               ori_ok;
        logic               last;
    } item_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PREP, ST_ITER, ST_SEL, ST_SQ, ST_NUM, ST_DVI, ST_DIV, ST_ACC, ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        TERM_BEAR, TERM_RANGE, TERM_ORI
    } term_t;

    localparam int ATAN_LEN   = 24;
    localparam int SQRT_STEPS = 17;
    localparam int DIV_STEPS  = 16;
    localparam int DIV_BITS   = 2;
    localparam logic [19:0] PI_SQ_Q16 = 20'd646814;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;
            5'd15: v = 32'h0000517C;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A2F;
            5'd19: v = 32'h00000517;
            5'd20: v = 32'h0000028B;
            5'd21: v = 32'h00000145;
            5'd22: v = 32'h000000A2;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/lam_front.sv
`timescale 1ns / 1ps
module lam_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lam_pkg::cfg_t        cfg,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [15:0]   s_particle_x,
    input  logic signed [15:0]   s_particle_y,
    input  logic signed [15:0]   s_particle_heading,
    input  logic [14:0]          s_obs_range,
    input  logic signed [15:0]   s_obs_bearing,
    input  logic signed [15:0]   s_obs_orientation,
    input  logic signed [15:0]   s_landmark_x,
    input  logic signed [15:0]   s_landmark_y,
    input  logic signed [15:0]   s_landmark_orientation,
    input  logic                 s_position_valid,
    input  logic                 s_orientation_valid,
    input  logic                 s_last_candidate,
    output logic                 q_valid,
    output lam_pkg::item_t       q_item,
    input  logic                 q_pop
);
    localparam int Q_DEPTH = 2;
    localparam int PTR_W   = $clog2(Q_DEPTH);

    lam_pkg::item_t            item;
    lam_pkg::item_t            mem_reg [Q_DEPTH];
    logic [PTR_W-1:0]          wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]            fill_reg;
    logic                      push;

    always_comb begin
        item.dx        = {s_landmark_x[15], s_landmark_x} - {s_particle_x[15], s_particle_x};
        item.dy        = {s_landmark_y[15], s_landmark_y} - {s_particle_y[15], s_particle_y};
        item.heading   = s_particle_heading;
        item.range     = s_obs_range;
        item.bearing   = s_obs_bearing;
        item.ori_innov = s_obs_orientation - s_landmark_orientation + s_particle_heading;
        item.gate_open = s_position_valid && (s_obs_range < cfg.range_gate);
        item.ori_ok    = s_orientation_valid;
        item.last      = s_last_candidate;
    end

    assign s_ready = (fill_reg != (PTR_W+1)'(Q_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (fill_reg != '0);
    assign q_item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, q_pop})
                2'b10:   fill_reg <= fill_reg + 1'b1;
                2'b01:   fill_reg <= fill_reg - 1'b1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

endmodule

// File: hdl/lam_back.sv
`timescale 1ns / 1ps
module lam_back #(
    parameter int MAX_CANDIDATES = 16,
    parameter int CORDIC_STEPS   = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  lam_pkg::cfg_t   cfg,
    input  logic            q_valid,
    input  lam_pkg::item_t  q_item,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [31:0]     m_best_distance,
    output logic [3:0]      m_best_index,
    output logic            m_run_overflow
);
    localparam int CORDIC_N = (CORDIC_STEPS > lam_pkg::ATAN_LEN) ? lam_pkg::ATAN_LEN
                                                                 : CORDIC_STEPS;
    localparam int ITER_N   = (CORDIC_N > lam_pkg::SQRT_STEPS + 1) ? CORDIC_N
                                                                    : lam_pkg::SQRT_STEPS + 1;
    localparam int CNT_W    = $clog2(ITER_N);
    localparam int RUN_W    = $clog2(MAX_CANDIDATES + 1);
    localparam int LIMIT    = (MAX_CANDIDATES - 1 > 15) ? 15 : MAX_CANDIDATES - 1;

    lam_pkg::state_t       state_reg, state_next;
    lam_pkg::item_t        item_reg;
    lam_pkg::term_t        term_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic signed [27:0]    x_reg, y_reg;
    logic [31:0]           z_reg;
    logic [31:0]           dx2_reg, dy2_reg;
    logic [33:0]           sq_rem_reg, sq_res_reg, sq_bit_reg;
    logic                  pend_bear_reg, pend_range_reg, pend_ori_reg;
    logic [35:0]           a2_reg, s2_reg;
    logic [51:0]           num_reg;
    logic [43:0]           den_reg;
    logic [44:0]           rem_reg;
    logic [31:0]           numlo_reg, q_reg;
    logic                  sat_reg;
    logic [33:0]           acc_reg;
    logic [31:0]           min_reg;
    logic [3:0]            best_reg;
    logic [RUN_W-1:0]      run_cnt_reg;
    logic                  m_valid_reg, m_over_reg;
    logic [31:0]           m_dist_reg;
    logic [3:0]            m_idx_reg;

    // CORDIC init and step
    logic signed [27:0]    xe, ye, xs, ys;
    // square root step
    logic [33:0]           sq_trial;
    // term operands
    logic [31:0]           z_round;
    logic [15:0]           atan16, eb, b_innov;
    logic [16:0]           norm;
    logic signed [17:0]    r_innov, op_a;
    logic [17:0]           op_s;
    logic [15:0]           astd, dstd, cstd;
    logic signed [35:0]    a2_s;
    // division step
    logic [44:0]           dv_r;
    logic [31:0]           dv_n, dv_q;
    // result
    logic [31:0]           d32;
    logic                  take, over, out_busy, hold_done, emit;
    logic [3:0]            idx;

    assign q_pop   = (state_reg == lam_pkg::ST_IDLE) && q_valid;
    assign m_valid = m_valid_reg;
    assign m_best_distance = m_dist_reg;
    assign m_best_index    = m_idx_reg;
    assign m_run_overflow  = m_over_reg;

    always_comb begin
        xe = 28'(signed'({{3{q_item.dx[16]}}, q_item.dx, 8'h00}));
        ye = 28'(signed'({{3{q_item.dy[16]}}, q_item.dy, 8'h00}));
        xs = x_reg >>> cnt_reg;
        ys = y_reg >>> cnt_reg;
        sq_trial = sq_res_reg + sq_bit_reg;
    end

    always_comb begin
        astd = (cfg.angle_std == 16'd0) ? 16'd1 : cfg.angle_std;
        dstd = (cfg.distance_std == 16'd0) ? 16'd1 : cfg.distance_std;
        cstd = (cfg.compass_std == 16'd0) ? 16'd1 : cfg.compass_std;
        z_round = z_reg + 32'h0000_8000;
        atan16  = z_round[31:16];
        eb      = (item_reg.dx != '0 || item_reg.dy != '0) ? atan16 - item_reg.heading : 16'd0;
        b_innov = item_reg.bearing - eb;
        norm    = sq_res_reg[16:0];
        r_innov = signed'({3'b000, item_reg.range}) - signed'({1'b0, norm});
        case (term_reg)
            lam_pkg::TERM_BEAR: begin
                op_a = signed'({{2{b_innov[15]}}, b_innov});
                op_s = {2'b00, astd};
            end
            lam_pkg::TERM_RANGE: begin
                op_a = r_innov;
                op_s = {2'b00, dstd} + {1'b0, item_reg.range, 2'b00};
            end
            lam_pkg::TERM_ORI: begin
                op_a = signed'({{2{item_reg.ori_innov[15]}}, item_reg.ori_innov});
                op_s = {2'b00, cstd};
            end
            default: begin
                op_a = '0;
                op_s = 18'd1;
            end
        endcase
        a2_s = op_a * op_a;
    end

    // restoring division, DIV_BITS quotient bits per cycle
    always_comb begin
        dv_r = rem_reg;
        dv_n = numlo_reg;
        dv_q = q_reg;
        for (int k = 0; k < lam_pkg::DIV_BITS; k++) begin
            dv_r = {dv_r[43:0], dv_n[31]};
            dv_n = {dv_n[30:0], 1'b0};
            dv_q = {dv_q[30:0], 1'b0};
            if (dv_r >= {1'b0, den_reg}) begin
                dv_r = dv_r - {1'b0, den_reg};
                dv_q[0] = 1'b1;
            end
        end
    end

    always_comb begin
        d32      = (acc_reg[33:32] != 2'b00) ? 32'hFFFF_FFFF : acc_reg[31:0];
        take     = (run_cnt_reg == '0) || (d32 <= min_reg);
        over     = (run_cnt_reg >= RUN_W'(MAX_CANDIDATES));
        idx      = (run_cnt_reg > RUN_W'(LIMIT)) ? 4'(LIMIT) : 4'(run_cnt_reg);
        out_busy = m_valid_reg && !m_ready;
        hold_done = item_reg.last && out_busy;
        emit     = (state_reg == lam_pkg::ST_DONE) && !hold_done && item_reg.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lam_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lam_pkg::ST_IDLE: begin
                if (q_valid) begin
                    state_next = q_item.gate_open ? lam_pkg::ST_PREP : lam_pkg::ST_SEL;
                end
            end
            lam_pkg::ST_PREP: state_next = lam_pkg::ST_ITER;
            lam_pkg::ST_ITER: begin
                if (cnt_reg == CNT_W'(ITER_N - 1)) begin
                    state_next = lam_pkg::ST_SEL;
                end
            end
            lam_pkg::ST_SEL: begin
                state_next = (pend_bear_reg || pend_range_reg || pend_ori_reg)
                           ? lam_pkg::ST_SQ : lam_pkg::ST_DONE;
            end
            lam_pkg::ST_SQ:  state_next = lam_pkg::ST_NUM;
            lam_pkg::ST_NUM: state_next = lam_pkg::ST_DVI;
            lam_pkg::ST_DVI: state_next = lam_pkg::ST_DIV;
            lam_pkg::ST_DIV: begin
                if (cnt_reg == CNT_W'(lam_pkg::DIV_STEPS - 1)) begin
                    state_next = lam_pkg::ST_ACC;
                end
            end
            lam_pkg::ST_ACC: state_next = lam_pkg::ST_SEL;
            lam_pkg::ST_DONE: begin
                if (!hold_done) begin
                    state_next = lam_pkg::ST_IDLE;
                end
            end
            default: state_next = lam_pkg::ST_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            lam_pkg::ST_IDLE: begin
                item_reg <= q_item;
                acc_reg  <= '0;
                if (q_item.dx < 0) begin
                    x_reg <= -xe;
                    y_reg <= -ye;
                    z_reg <= 32'h8000_0000;
                end else begin
                    x_reg <= xe;
                    y_reg <= ye;
                    z_reg <= 32'h0;
                end
            end
            lam_pkg::ST_PREP: begin
                dx2_reg <= 32'(unsigned'(34'(item_reg.dx) * 34'(item_reg.dx)));
                dy2_reg <= 32'(unsigned'(34'(item_reg.dy) * 34'(item_reg.dy)));
            end
            lam_pkg::ST_ITER: begin
                if (cnt_reg < CNT_W'(CORDIC_N)) begin
                    if (y_reg > 0) begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + lam_pkg::atan_entry(5'(cnt_reg));
                    end else begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - lam_pkg::atan_entry(5'(cnt_reg));
                    end
                end
                if (cnt_reg == '0) begin
                    sq_rem_reg <= {2'b00, dx2_reg} + {2'b00, dy2_reg};
                    sq_res_reg <= '0;
                    sq_bit_reg <= 34'h1_0000_0000;
                end else if (sq_bit_reg != '0) begin
                    if (sq_rem_reg >= sq_trial) begin
                        sq_rem_reg <= sq_rem_reg - sq_trial;
                        sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                    end else begin
                        sq_res_reg <= sq_res_reg >> 1;
                    end
                    sq_bit_reg <= sq_bit_reg >> 2;
                end
            end
            lam_pkg::ST_SQ: begin
                a2_reg <= unsigned'(a2_s);
                s2_reg <= op_s * op_s;
            end
            lam_pkg::ST_NUM: begin
                if (term_reg == lam_pkg::TERM_RANGE) begin
                    num_reg <= 52'({a2_reg, 15'h0000});
                    den_reg <= 44'(s2_reg);
                end else begin
                    num_reg <= 52'(a2_reg) * 52'(lam_pkg::PI_SQ_Q16);
                    den_reg <= 44'({s2_reg, 11'h000});
                end
            end
            lam_pkg::ST_DVI: begin
                sat_reg   <= ({24'h0, num_reg[51:32]} >= den_reg);
                rem_reg   <= {25'h0, num_reg[51:32]};
                numlo_reg <= num_reg[31:0];
                q_reg     <= '0;
            end
            lam_pkg::ST_DIV: begin
                rem_reg   <= dv_r;
                numlo_reg <= dv_n;
                q_reg     <= dv_q;
            end
            lam_pkg::ST_ACC: begin
                acc_reg <= acc_reg + (sat_reg ? 34'h1_0000_0000 : {2'b00, q_reg});
            end
            default: begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    // control: counters, pending terms, run tracking and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg        <= '0;
            term_reg       <= lam_pkg::TERM_BEAR;
            pend_bear_reg  <= 1'b0;
            pend_range_reg <= 1'b0;
            pend_ori_reg   <= 1'b0;
            min_reg        <= '0;
            best_reg       <= '0;
            run_cnt_reg    <= '0;
            m_valid_reg    <= 1'b0;
            m_dist_reg     <= '0;
            m_idx_reg      <= '0;
            m_over_reg     <= 1'b0;
        end else begin
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg) inside
                lam_pkg::ST_IDLE: begin
                    pend_bear_reg  <= q_item.gate_open;
                    pend_range_reg <= q_item.gate_open;
                    pend_ori_reg   <= q_item.ori_ok;
                end
                lam_pkg::ST_PREP, lam_pkg::ST_DVI: cnt_reg <= '0;
                lam_pkg::ST_ITER, lam_pkg::ST_DIV: cnt_reg <= cnt_reg + 1'b1;
                lam_pkg::ST_SEL: begin
                    if (pend_bear_reg) begin
                        term_reg      <= lam_pkg::TERM_BEAR;
                        pend_bear_reg <= 1'b0;
                    end else if (pend_range_reg) begin
                        term_reg       <= lam_pkg::TERM_RANGE;
                        pend_range_reg <= 1'b0;
                    end else if (pend_ori_reg) begin
                        term_reg     <= lam_pkg::TERM_ORI;
                        pend_ori_reg <= 1'b0;
                    end
                end
                lam_pkg::ST_DONE: begin
                    if (!hold_done) begin
                        if (item_reg.last) begin
                            // emit the run and start a fresh one
                            m_dist_reg  <= take ? d32 : min_reg;
                            m_idx_reg   <= take ? idx : best_reg;
                            m_over_reg  <= over;
                            min_reg     <= '0;
                            best_reg    <= '0;
                            run_cnt_reg <= '0;
                        end else begin
                            if (take) begin
                                min_reg  <= d32;
                                best_reg <= idx;
                            end
                            if (!over) begin
                                run_cnt_reg <= run_cnt_reg + 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    cnt_reg <= cnt_reg;
                end
            endcase
        end
    end

endmodule

// File: hdl/landmark_association_mahalanobis.sv
`timescale 1ns / 1ps
// Scores one candidate landmark per request against one observation by
// Mahalanobis distance and, on the request marked last candidate, returns the
// smallest score of the run with its position (ties go to the later one).
// The front stage takes a request in any cycle while its two-entry queue has
// room; the back stage works one candidate at a time. A candidate inside the
// range gate runs the shared CORDIC/square-root loop and then its bearing and
// range terms; a candidate with valid orientation also runs its orientation
// term. Each term passes through the two-bit-a-cycle divider. Configuration
// is written through cfg_we/cfg_index/cfg_data; the user must write it only
// while no candidate is in flight, which the block itself does not enforce.
module landmark_association_mahalanobis #(
    parameter int MAX_CANDIDATES = 16,
    parameter int CORDIC_STEPS   = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [15:0]   s_particle_x,
    input  logic signed [15:0]   s_particle_y,
    input  logic signed [15:0]   s_particle_heading,
    input  logic [14:0]          s_obs_range,
    input  logic signed [15:0]   s_obs_bearing,
    input  logic signed [15:0]   s_obs_orientation,
    input  logic signed [15:0]   s_landmark_x,
    input  logic signed [15:0]   s_landmark_y,
    input  logic signed [15:0]   s_landmark_orientation,
    input  logic                 s_position_valid,
    input  logic                 s_orientation_valid,
    input  logic                 s_last_candidate,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [31:0]          m_best_distance,
    output logic [3:0]           m_best_index,
    output logic                 m_run_overflow
);
    lam_pkg::cfg_t   cfg_reg;
    lam_pkg::item_t  q_item;
    logic            q_valid, q_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.angle_std    <= lam_pkg::ANGLE_STD_RST;
            cfg_reg.distance_std <= lam_pkg::DISTANCE_STD_RST;
            cfg_reg.compass_std  <= lam_pkg::COMPASS_STD_RST;
            cfg_reg.range_gate   <= lam_pkg::RANGE_GATE_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                lam_pkg::CFG_ANGLE_STD:    cfg_reg.angle_std    <= cfg_data;
                lam_pkg::CFG_DISTANCE_STD: cfg_reg.distance_std <= cfg_data;
                lam_pkg::CFG_COMPASS_STD:  cfg_reg.compass_std  <= cfg_data;
                lam_pkg::CFG_RANGE_GATE:   cfg_reg.range_gate   <= cfg_data[14:0];
                default: cfg_reg <= cfg_reg;
            endcase
        end
    end

    lam_front u_front (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg                   (cfg_reg),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_particle_x          (s_particle_x),
        .s_particle_y          (s_particle_y),
        .s_particle_heading    (s_particle_heading),
        .s_obs_range           (s_obs_range),
        .s_obs_bearing         (s_obs_bearing),
        .s_obs_orientation     (s_obs_orientation),
        .s_landmark_x          (s_landmark_x),
        .s_landmark_y          (s_landmark_y),
        .s_landmark_orientation(s_landmark_orientation),
        .s_position_valid      (s_position_valid),
        .s_orientation_valid   (s_orientation_valid),
        .s_last_candidate      (s_last_candidate),
        .q_valid               (q_valid),
        .q_item                (q_item),
        .q_pop                 (q_pop)
    );

    lam_back #(
        .MAX_CANDIDATES(MAX_CANDIDATES),
        .CORDIC_STEPS  (CORDIC_STEPS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_best_distance(m_best_distance),
        .m_best_index   (m_best_index),
        .m_run_overflow (m_run_overflow)
    );

endmodule

// File: hdl/lam_checker.sv
`timescale 1ns / 1ps
`include "landmark_association_mahalanobis_defines.svh"
module lam_checker (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_ready,
    input  logic          m_valid,
    input  logic          m_ready,
    input  logic [31:0]   m_best_distance,
    input  logic [3:0]    m_best_index,
    input  logic          m_run_overflow
);
    // queue is empty and no result is pending right after reset
    `LAM_ASSERT_ALWAYS(a_reset_state, !aresetn |=> (!m_valid && s_ready), "bad state after reset")
    // queue fills only through an accepted request
    `LAM_ASSERT(a_full_by_push, $fell(s_ready) |-> $past(s_valid), "s_ready fell without request")
    `LAM_ASSERT(a_out_hold, (m_valid && !m_ready) |=> m_valid, "result dropped under stall")
    `LAM_ASSERT(a_out_stable, (m_valid && !m_ready) |=> ($stable(m_best_distance) && $stable(m_best_index) && $stable(m_run_overflow)), "result changed under stall")

endmodule

bind landmark_association_mahalanobis lam_checker u_lam_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_best_distance (m_best_distance),
    .m_best_index    (m_best_index),
    .m_run_overflow  (m_run_overflow)
);
